// File: hdl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
   localparam int SAMPLE_W   = 32;
   localparam int MED_W      = SAMPLE_W + 1;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

   typedef struct packed {
      logic                       valid;
      logic [IDX_W-1:0]           age;
      logic signed [SAMPLE_W-1:0] value;
   } cell_type;

   typedef struct packed {
      logic clear;
      logic remove;
      logic insert;
   } cell_cmd_type;

   // neighbor tie-offs at the two ends of the chain
   localparam cell_type CELL_LEFT_END  = '{valid: 1'b1, age: '0, value: '0};
   localparam cell_type CELL_RIGHT_END = '{valid: 1'b0, age: '0, value: '0};

endpackage

// File: hdl/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  swm_pkg::cell_cmd_type              cmd,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] remove_val,
   input  logic [swm_pkg::IDX_W-1:0]          len_m1,
   input  swm_pkg::cell_type                  left,
   input  logic                               left_gt,
   input  swm_pkg::cell_type                  right,
   output swm_pkg::cell_type                  slot,
   output logic                               gt,
   output logic                               rm
);
   import swm_pkg::*;

   logic                       valid_ff, valid_in;
   logic [IDX_W-1:0]           age_ff, age_in;
   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic                       take_sample;

   assign slot = '{valid: valid_ff, age: age_ff, value: value_ff};

   always_comb begin
      gt = valid_ff && ($signed(value_ff) > $signed(sample));
      rm = valid_ff && (age_ff == len_m1);
      // new item lands in the first slot that is above it or empty
      take_sample = !left_gt && (gt || !valid_ff) && left.valid;

      valid_in = valid_ff;
      age_in   = age_ff;
      value_in = value_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.remove) begin
         // equal values sit oldest first, so >= covers the evicted cell and all above it
         if (valid_ff && ($signed(value_ff) >= $signed(remove_val))) begin
            valid_in = right.valid;
            age_in   = right.age;
            value_in = right.value;
         end
      end else if (cmd.insert) begin
         if (left_gt) begin
            valid_in = left.valid;
            age_in   = left.age + IDX_W'(1);
            value_in = left.value;
         end else if (take_sample) begin
            valid_in = 1'b1;
            age_in   = '0;
            value_in = sample;
         end else begin
            age_in = age_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff   <= age_in;
      value_ff <= value_in;
   end

endmodule

// File: hdl/swm_tap.sv
`timescale 1ns / 1ps

module swm_tap (
   input  logic                                clock,
   input  logic                                load,
   input  logic [swm_pkg::LEN_W-1:0]           len,
   input  swm_pkg::cell_type                   cells [swm_pkg::WINDOW_MAX],
   output logic signed [swm_pkg::MED_W-1:0]    median_x2
);
   import swm_pkg::*;

   logic [IDX_W-1:0]           mid_idx;
   logic [IDX_W-1:0]           low_idx;
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in;

   always_comb begin
      mid_idx = IDX_W'(len >> 1);
      low_idx = mid_idx - IDX_W'(1);
      hi_in   = cells[mid_idx].value;
      // odd length doubles the middle entry
      lo_in   = len[0] ? cells[mid_idx].value : cells[low_idx].value;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign median_x2 = $signed({hi_ff[SAMPLE_W-1], hi_ff}) + $signed({lo_ff[SAMPLE_W-1], lo_ff});

endmodule

// File: hdl/sliding_window_median.sv
`timescale 1ns / 1ps

// channel  ports                                    direction
// req      req_valid req_stall req_sample req_start_req   in (stall out)
// rsp      rsp_valid rsp_stall rsp_median_x2        out (stall in)
// csr      csr_write_en csr_write_data              in, window length
//
// While the window fills an item is accepted and inserted through the cell chain;
// the item that fills it also passes tap select and sum, and once full an item goes
// accept, evict through the cell chain, insert through the chain, tap select, sum.
// Reset (or a csr write) empties the window and sets length 3 on reset.
// A held result keeps the next result waiting in the sum step, which stalls new items.

module sliding_window_median (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [swm_pkg::MED_W-1:0]    rsp_median_x2,
   input  logic                                csr_write_en,
   input  logic [swm_pkg::LEN_W-1:0]           csr_write_data
);
   import swm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REMOVE = 5'b00010,
      ST_INSERT = 5'b00100,
      ST_SELECT = 5'b01000,
      ST_SUM    = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [LEN_W-1:0]           window_len_ff, window_len_in;
   logic [LEN_W-1:0]           fill_ff, fill_in;
   logic [LEN_W-1:0]           fill_base;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_W-1:0] evict_ff, evict_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MED_W-1:0]    rsp_median_ff, rsp_median_in;

   logic [LEN_W-1:0]           len_eff;
   logic [LEN_W-1:0]           len_dec;
   logic [IDX_W-1:0]           len_m1;
   logic                       accept;
   logic                       out_free;
   logic                       tap_load;
   logic signed [MED_W-1:0]    tap_sum;
   cell_cmd_type               cmd;

   cell_type                   cells [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]      gt_vec;
   logic [WINDOW_MAX-1:0]      rm_vec;
   logic [WINDOW_MAX-1:0]      valid_vec;

   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (window_len_ff > LEN_W'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = window_len_ff;
      end
      len_dec = len_eff - LEN_W'(1);
      len_m1  = len_dec[IDX_W-1:0];
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_median_x2 = rsp_median_ff;

   // value of the oldest cell, picked by its age tag
   always_comb begin
      evict_in = evict_ff;
      if (accept) begin
         evict_in = '0;
         for (int i = 0; i < WINDOW_MAX; i++) begin
            evict_in = evict_in | (rm_vec[i] ? cells[i].value : '0);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      fill_in       = fill_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_median_in = rsp_median_ff;
      tap_load      = 1'b0;
      cmd           = '0;
      fill_base     = req_start_req ? '0 : fill_ff;

      if (csr_write_en) begin
         window_len_in = csr_write_data;
         fill_in       = '0;
         cmd.clear     = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               cmd.clear = req_start_req;
               if (fill_base == len_eff) begin
                  fill_in  = fill_base;
                  state_in = ST_REMOVE;
               end else begin
                  fill_in  = fill_base + LEN_W'(1);
                  state_in = ST_INSERT;
               end
            end
         end
         ST_REMOVE: begin
            cmd.remove = 1'b1;
            state_in   = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = (fill_ff == len_eff) ? ST_SELECT : ST_IDLE;
         end
         ST_SELECT: begin
            tap_load = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = tap_sum;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= LEN_RESET;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      evict_ff      <= evict_in;
      rsp_median_ff <= rsp_median_in;
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      cell_type left_c;
      cell_type right_c;
      logic     left_gt;

      if (i == 0) begin : g_first
         assign left_c  = CELL_LEFT_END;
         assign left_gt = 1'b0;
      end else begin : g_mid
         assign left_c  = cells[i-1];
         assign left_gt = gt_vec[i-1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign right_c = CELL_RIGHT_END;
      end else begin : g_inner
         assign right_c = cells[i+1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .sample     (sample_ff),
         .remove_val (evict_ff),
         .len_m1     (len_m1),
         .left       (left_c),
         .left_gt    (left_gt),
         .right      (right_c),
         .slot       (cells[i]),
         .gt         (gt_vec[i]),
         .rm         (rm_vec[i])
      );

      assign valid_vec[i] = cells[i].valid;
   end

   swm_tap u_tap (
      .clock     (clock),
      .load      (tap_load),
      .len       (len_eff),
      .cells     (cells),
      .median_x2 (tap_sum)
   );

`ifndef SYNTHESIS
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_eff)
      else $error("window fill above length");

   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == fill_ff))
      else $error("occupied cells disagree with fill count");

   a_single_oldest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> $onehot0(rm_vec))
      else $error("more than one cell tagged oldest");

   a_oldest_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REMOVE) |-> $onehot(rm_vec))
      else $error("full window has no oldest cell");

   a_result_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_SUM))
      else $error("result raised outside the sum step");
`endif

endmodule
